>>> rtl/ntn_pkg.sv
// Shared types and byte constants for the name text normalizer.
`default_nettype none

package ntn_pkg;

   // UTF-8 lead byte of the Latin-1 supplement block.
   localparam logic [7:0] LEAD_BYTE = 8'hC3;

   // Follower bytes of the accented vowels, lower case then upper case.
   localparam logic [7:0] FOL_A_LO  = 8'hA1;
   localparam logic [7:0] FOL_A_UP  = 8'h81;
   localparam logic [7:0] FOL_E_LO  = 8'hA9;
   localparam logic [7:0] FOL_E_UP  = 8'h89;
   localparam logic [7:0] FOL_I_LO  = 8'hAD;
   localparam logic [7:0] FOL_I_UP  = 8'h8D;
   localparam logic [7:0] FOL_O_LO  = 8'hB3;
   localparam logic [7:0] FOL_O_UP  = 8'h93;
   localparam logic [7:0] FOL_U_LO  = 8'hBA;
   localparam logic [7:0] FOL_U_UP  = 8'h9A;
   localparam logic [7:0] FOL_UU_LO = 8'hBC;
   localparam logic [7:0] FOL_UU_UP = 8'h9C;

   // Distance between ASCII upper and lower case.
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Most result words that one entry can produce.
   localparam int RES_PER_ENTRY = 3;

   // One classified input word: up to two folded characters.
   typedef struct packed {
      logic       has0;
      logic [7:0] ch0;
      logic       has1;
      logic [7:0] ch1;
      logic       last;
   } ntn_entry_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
   } ntn_result_type;

   typedef ntn_result_type [RES_PER_ENTRY-1:0] ntn_burst_type;

endpackage

`default_nettype wire

>>> rtl/ntn_front.sv
// Front end: accepts raw bytes, folds accented vowels and classifies them into entries.
`default_nettype none

module ntn_front import ntn_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [7:0]    in_byte,
   input  wire logic          in_last,
   input  wire logic          q_full,
   output logic               q_push,
   output ntn_entry_type      q_entry
);

   logic lead_pending_ff;
   logic lead_pending_in;
   logic accept;
   logic [7:0] folded;

   // Map a follower byte to its plain vowel, or zero when it is no accented vowel.
   function automatic logic [7:0] fold_of(input logic [7:0] f);
      logic [7:0] v;
      begin
         case (f)
            FOL_A_LO, FOL_A_UP:   v = "a";
            FOL_E_LO, FOL_E_UP:   v = "e";
            FOL_I_LO, FOL_I_UP:   v = "i";
            FOL_O_LO, FOL_O_UP:   v = "o";
            FOL_U_LO, FOL_U_UP:   v = "u";
            FOL_UU_LO, FOL_UU_UP: v = "u";
            default:              v = 8'h00;
         endcase
         return v;
      end
   endfunction

   assign accept = push && !q_full;
   assign folded = fold_of(in_byte);

   // Build the entry of folded characters for this word.
   always_comb begin
      q_entry = '0;
      lead_pending_in = lead_pending_ff;
      if (lead_pending_ff) begin
         q_entry.has0 = 1'b1;
         if (folded != 8'h00) begin
            q_entry.ch0 = folded;
            lead_pending_in = 1'b0;
         end else begin
            // The held lead is passed on; this byte is handled afresh.
            q_entry.ch0 = LEAD_BYTE;
            if (in_byte == LEAD_BYTE) begin
               if (in_last) begin
                  q_entry.has1 = 1'b1;
                  q_entry.ch1 = LEAD_BYTE;
               end
               lead_pending_in = 1'b1;
            end else begin
               q_entry.has1 = 1'b1;
               q_entry.ch1 = in_byte;
               lead_pending_in = 1'b0;
            end
         end
      end else if (in_byte == LEAD_BYTE) begin
         if (in_last) begin
            q_entry.has0 = 1'b1;
            q_entry.ch0 = LEAD_BYTE;
         end
         lead_pending_in = 1'b1;
      end else begin
         q_entry.has0 = 1'b1;
         q_entry.ch0 = in_byte;
      end
      q_entry.last = in_last;
      if (in_last) begin
         lead_pending_in = 1'b0;
      end
   end

   // A lone lead byte in mid string produces no entry yet.
   assign q_push = accept && (q_entry.has0 || q_entry.last);

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
      end else if (accept) begin
         lead_pending_ff <= lead_pending_in;
      end
   end

`ifndef SYNTHESIS
   // The end of a string always leaves no lead byte waiting.
   a_last_clears_lead: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> !lead_pending_ff)
      else $error("lead byte still pending after end of string");
`endif

endmodule

`default_nettype wire

>>> rtl/ntn_entry_q.sv
// Short queue of classified entries between the front end and the back end.
`default_nettype none

module ntn_entry_q import ntn_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire ntn_entry_type wr_entry,
   output logic               full,
   input  wire logic          rd_en,
   output ntn_entry_type      rd_entry,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ntn_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic do_wr;
   logic do_rd;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_entry = slot_ff[rd_ptr_ff];

   // Pointer and occupancy updates with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ntn_back.sv
// Back end: trims and collapses whitespace, sets word case and forms result words.
`default_nettype none

module ntn_back import ntn_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          entry_valid,
   input  wire ntn_entry_type entry,
   output logic               entry_pop,
   input  wire logic          space_ok,
   output logic [1:0]         wr_cnt,
   output ntn_burst_type      wr_data
);

   logic       text_started_ff;
   logic       text_started_in;
   logic       space_pending_ff;
   logic       space_pending_in;
   logic [7:0] held_space_ff;
   logic [7:0] held_space_in;
   logic       word_start_ff;
   logic       word_start_in;

   // Whitespace is tab through carriage return, and space.
   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
   endfunction

   assign entry_pop = entry_valid && space_ok;

   // Run both characters of the entry through the shaping rules in order.
   always_comb begin
      logic [7:0] c;
      logic       has_c;
      logic [1:0] cnt;
      text_started_in = text_started_ff;
      space_pending_in = space_pending_ff;
      held_space_in = held_space_ff;
      word_start_in = word_start_ff;
      wr_data = '0;
      cnt = 2'd0;
      for (int k = 0; k < 2; k++) begin
         has_c = (k == 0) ? entry.has0 : entry.has1;
         c = (k == 0) ? entry.ch0 : entry.ch1;
         if (has_c) begin
            if (is_ws(c)) begin
               // Only the first whitespace after text is held.
               if (text_started_in && !space_pending_in) begin
                  space_pending_in = 1'b1;
                  held_space_in = c;
               end
            end else begin
               if (space_pending_in) begin
                  wr_data[cnt].data = held_space_in;
                  wr_data[cnt].has = 1'b1;
                  cnt = cnt + 2'd1;
                  space_pending_in = 1'b0;
                  word_start_in = 1'b1;
               end
               if (word_start_in && (c inside {["a":"z"]})) begin
                  c = c - CASE_DELTA;
               end else if (!word_start_in && (c inside {["A":"Z"]})) begin
                  c = c + CASE_DELTA;
               end
               word_start_in = 1'b0;
               text_started_in = 1'b1;
               wr_data[cnt].data = c;
               wr_data[cnt].has = 1'b1;
               cnt = cnt + 2'd1;
            end
         end
      end
      // End of string: mark the final word, or give an empty marker.
      if (entry.last) begin
         if (cnt == 2'd0) begin
            wr_data[0].data = 8'h00;
            wr_data[0].has = 1'b0;
            cnt = 2'd1;
         end
         wr_data[cnt - 2'd1].last = 1'b1;
         text_started_in = 1'b0;
         space_pending_in = 1'b0;
         held_space_in = 8'h00;
         word_start_in = 1'b1;
      end
      wr_cnt = entry_pop ? cnt : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_started_ff <= 1'b0;
         space_pending_ff <= 1'b0;
         held_space_ff <= 8'h00;
         word_start_ff <= 1'b1;
      end else if (entry_pop) begin
         text_started_ff <= text_started_in;
         space_pending_ff <= space_pending_in;
         held_space_ff <= held_space_in;
         word_start_ff <= word_start_in;
      end
   end

`ifndef SYNTHESIS
   // A space is held only after some text has gone out.
   a_space_after_text: assert property (@(posedge clock) disable iff (reset)
      space_pending_ff |-> text_started_ff)
      else $error("whitespace held before any text");

   // Finishing a string returns the shaping state to its start.
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      entry_pop && entry.last |=> word_start_ff && !text_started_ff && !space_pending_ff)
      else $error("shaping state not cleared after end of string");
`endif

endmodule

`default_nettype wire

>>> rtl/ntn_out_q.sv
// Output queue that takes up to three result words a cycle and gives one.
`default_nettype none

module ntn_out_q import ntn_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [1:0]    wr_cnt,
   input  wire ntn_burst_type wr_data,
   output logic               space_ok,
   input  wire logic          pop,
   output logic               empty,
   output ntn_result_type     rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ntn_result_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic do_rd;

   // Advance a pointer by a few places, wrapping at the depth.
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [1:0] k);
      logic [PTR_W:0] s;
      begin
         s = {1'b0, p} + (PTR_W + 1)'(k);
         if (s >= (PTR_W + 1)'(DEPTH)) begin
            s = s - (PTR_W + 1)'(DEPTH);
         end
         return s[PTR_W-1:0];
      end
   endfunction

   assign empty = (count_ff == '0);
   assign do_rd = pop && !empty;
   assign space_ok = (count_ff <= CNT_W'(DEPTH - RES_PER_ENTRY));
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = ptr_add(wr_ptr_ff, wr_cnt);
      rd_ptr_in = do_rd ? ptr_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(wr_cnt) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Write the burst into consecutive slots.
   always_ff @(posedge clock) begin
      for (int k = 0; k < RES_PER_ENTRY; k++) begin
         if (2'(k) < wr_cnt) begin
            slot_ff[ptr_add(wr_ptr_ff, 2'(k))] <= wr_data[k];
         end
      end
   end

`ifndef SYNTHESIS
   // The back end never writes more words than there is room for.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_cnt != 2'd0 |-> count_ff <= CNT_W'(DEPTH - RES_PER_ENTRY))
      else $error("output queue written without room");
`endif

endmodule

`default_nettype wire

>>> rtl/name_text_normalizer_top.sv
// Top level of the name text normalizer.
`default_nettype none

// The normalizer takes one byte of a string per cycle and gives a normalized
// byte stream: accented Spanish vowels in UTF-8 fold to plain lower-case
// vowels, leading and trailing whitespace is dropped, inner whitespace runs
// keep only their first character, and each word is title-cased. A byte is
// taken in every cycle in which full is low. The front end writes its
// entries into the entry queue; the back end shapes the head entry into
// result words in the output queue, whose head word is on the rsp_ ports.
// The back end takes an entry only while the output queue has room for
// three more words; otherwise it waits for pops. The back end handles one
// queued entry per cycle and the output queue gives one word per cycle, so
// the sustained rate is one byte per cycle as long as words are popped as
// fast as they come. A string that yields no bytes still gives one word
// with rsp_has_byte low and rsp_out_last high. There is no start-up pass
// after reset. OUT_DEPTH must be at least four.
module name_text_normalizer_top import ntn_pkg::*; #(
   parameter int ENTRY_DEPTH = 4,
   parameter int OUT_DEPTH = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_in_byte,
   input  wire logic          req_in_last,
   output logic               empty,
   input  wire logic          pop,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_has_byte,
   output logic               rsp_out_last
);

   logic           q_push;
   ntn_entry_type  q_entry;
   logic           q_empty;
   ntn_entry_type  head_entry;
   logic           entry_pop;
   logic           space_ok;
   logic [1:0]     wr_cnt;
   ntn_burst_type  wr_data;
   ntn_result_type rsp_word;

   ntn_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .q_full  (full),
      .q_push  (q_push),
      .q_entry (q_entry)
   );

   ntn_entry_q #(.DEPTH(ENTRY_DEPTH)) u_entry_q (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_entry),
      .full     (full),
      .rd_en    (entry_pop),
      .rd_entry (head_entry),
      .empty    (q_empty)
   );

   ntn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (!q_empty),
      .entry       (head_entry),
      .entry_pop   (entry_pop),
      .space_ok    (space_ok),
      .wr_cnt      (wr_cnt),
      .wr_data     (wr_data)
   );

   ntn_out_q #(.DEPTH(OUT_DEPTH)) u_out_q (
      .clock    (clock),
      .reset    (reset),
      .wr_cnt   (wr_cnt),
      .wr_data  (wr_data),
      .space_ok (space_ok),
      .pop      (pop),
      .empty    (empty),
      .rd_data  (rsp_word)
   );

   assign rsp_out_byte = rsp_word.data;
   assign rsp_has_byte = rsp_word.has;
   assign rsp_out_last = rsp_word.last;

endmodule

`default_nettype wire

>>> tb/ntn_checker.sv
// Checker for the name text normalizer: predicts result words and compares them.
`default_nettype none

module ntn_checker import ntn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic       full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   input  wire logic       empty,
   input  wire logic       pop,
   input  wire logic [7:0] rsp_out_byte,
   input  wire logic       rsp_has_byte,
   input  wire logic       rsp_out_last,
   output int              fail_count,
   output int              pending_count,
   output int              result_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] WS_TAB   = 8'h09;
   localparam logic [7:0] WS_CR    = 8'h0D;
   localparam logic [7:0] WS_SPACE = 8'h20;
   localparam logic [7:0] CHR_UP_A = 8'h41;
   localparam logic [7:0] CHR_UP_Z = 8'h5A;
   localparam logic [7:0] CHR_LO_A = 8'h61;
   localparam logic [7:0] CHR_LO_E = 8'h65;
   localparam logic [7:0] CHR_LO_I = 8'h69;
   localparam logic [7:0] CHR_LO_O = 8'h6F;
   localparam logic [7:0] CHR_LO_U = 8'h75;
   localparam logic [7:0] CHR_LO_Z = 8'h7A;
   localparam logic [7:0] NO_FOLD  = 8'h00;
   localparam int         MAX_WORDS_PER_BYTE = 4;

   // Shadow copy of the normalizer state.
   logic       lead_pending;
   logic       text_started;
   logic       space_pending;
   logic [7:0] held_space;
   logic       word_start;

   ntn_result_type step_words[$];
   ntn_result_type expected_words[$];
   int             fails = 0;
   int             checked = 0;

   function automatic logic is_space(input logic [7:0] c);
      return (c == WS_SPACE) || (c >= WS_TAB && c <= WS_CR);
   endfunction

   // Plain vowel for an accent follower, or NO_FOLD when the byte is not one.
   function automatic logic [7:0] fold_follower(input logic [7:0] f);
      case (f)
         FOL_A_LO, FOL_A_UP: return CHR_LO_A;
         FOL_E_LO, FOL_E_UP: return CHR_LO_E;
         FOL_I_LO, FOL_I_UP: return CHR_LO_I;
         FOL_O_LO, FOL_O_UP: return CHR_LO_O;
         FOL_U_LO, FOL_U_UP, FOL_UU_LO, FOL_UU_UP: return CHR_LO_U;
         default: return NO_FOLD;
      endcase
   endfunction

   task automatic clear_state();
      lead_pending = 1'b0;
      text_started = 1'b0;
      space_pending = 1'b0;
      held_space = '0;
      word_start = 1'b1;
   endtask

   task automatic emit_word(input logic [7:0] data, input logic has);
      ntn_result_type w;
      w.data = data;
      w.has = has;
      w.last = 1'b0;
      if (step_words.size() < MAX_WORDS_PER_BYTE) step_words.push_back(w);
   endtask

   // Trims and collapses whitespace and applies word casing to one folded byte.
   task automatic shape_byte(input logic [7:0] c_in);
      logic [7:0] c;
      c = c_in;
      if (is_space(c)) begin
         if (text_started && !space_pending) begin
            space_pending = 1'b1;
            held_space = c;
         end
      end else begin
         if (space_pending) begin
            emit_word(held_space, 1'b1);
            space_pending = 1'b0;
            word_start = 1'b1;
         end
         if (word_start) begin
            if (c >= CHR_LO_A && c <= CHR_LO_Z) c = c - CASE_DELTA;
         end else if (c >= CHR_UP_A && c <= CHR_UP_Z) begin
            c = c + CASE_DELTA;
         end
         word_start = 1'b0;
         text_started = 1'b1;
         emit_word(c, 1'b1);
      end
   endtask

   // Works out the result words of one accepted byte and queues them.
   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic [7:0]     folded;
      logic           handled;
      ntn_result_type w;
      step_words.delete();
      handled = 1'b0;
      if (lead_pending) begin
         lead_pending = 1'b0;
         folded = fold_follower(b);
         if (folded != NO_FOLD) begin
            shape_byte(folded);
            handled = 1'b1;
         end else begin
            // Not an accent follower: the lead passes and the byte starts afresh.
            shape_byte(LEAD_BYTE);
         end
      end
      if (!handled) begin
         if (b == LEAD_BYTE) lead_pending = 1'b1;
         else shape_byte(b);
      end
      if (last) begin
         if (lead_pending) shape_byte(LEAD_BYTE);
         if (step_words.size() == 0) emit_word('0, 1'b0);
         w = step_words.pop_back();
         w.last = 1'b1;
         step_words.push_back(w);
         clear_state();
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   // Watch both channels at each edge; results first, then new bytes.
   always @(posedge clock) begin : watch_channels
      ntn_result_type want;
      if (reset) begin
         clear_state();
         expected_words.delete();
      end else begin
         if (pop && !empty) begin
            checked++;
            if (expected_words.size() == 0) begin
               $error("unexpected result word: byte %02h has %0b last %0b",
                      rsp_out_byte, rsp_has_byte, rsp_out_last);
               fails++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("rsp_out_byte: expected %02h, actual %02h", want.data, rsp_out_byte);
                  fails++;
               end
               if (rsp_has_byte !== want.has) begin
                  $error("rsp_has_byte: expected %0b, actual %0b", want.has, rsp_has_byte);
                  fails++;
               end
               if (rsp_out_last !== want.last) begin
                  $error("rsp_out_last: expected %0b, actual %0b", want.last, rsp_out_last);
                  fails++;
               end
            end
         end
         if (push && !full) predict_byte(req_in_byte, req_in_last);
      end
      fail_count <= fails;
      pending_count <= expected_words.size();
      result_count <= checked;
   end

endmodule

`default_nettype wire

>>> tb/name_text_normalizer_top_tb.sv
// Testbench top for the name text normalizer: stimulus, receiver and verdict.
`default_nettype none

module name_text_normalizer_top_tb import ntn_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RESET_CYCLES   = 11;
   localparam int         STALL_LIMIT    = 2000;
   localparam int         DRAIN_LIMIT    = 4000;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         RANDOM_BYTES   = 410;
   localparam int         PAUSE_INTERVAL = 70;
   localparam logic [7:0] WS_TAB   = 8'h09;
   localparam logic [7:0] WS_LF    = 8'h0A;
   localparam logic [7:0] WS_VT    = 8'h0B;
   localparam logic [7:0] WS_FF    = 8'h0C;
   localparam logic [7:0] WS_CR    = 8'h0D;
   localparam logic [7:0] WS_SPACE = 8'h20;
   localparam logic [7:0] CHR_UP_A = 8'h41;
   localparam logic [7:0] CHR_UP_P = 8'h50;
   localparam logic [7:0] CHR_UP_Q = 8'h51;
   localparam logic [7:0] CHR_LO_A = 8'h61;
   localparam logic [7:0] CHR_LO_M = 8'h6D;
   localparam logic [7:0] CHR_LO_R = 8'h72;
   localparam logic [7:0] CHR_BANG = 8'h21;
   localparam logic [7:0] CHR_TILDE = 8'h7E;
   localparam logic [7:0] BYTE_MIN = 8'h00;
   localparam logic [7:0] BYTE_MAX = 8'hFF;

   localparam logic [7:0] SPACE_SET [6] = '{WS_TAB, WS_LF, WS_VT, WS_FF, WS_CR, WS_SPACE};
   localparam logic [7:0] FOLLOWER_SET [12] = '{
      FOL_A_LO, FOL_A_UP, FOL_E_LO, FOL_E_UP, FOL_I_LO, FOL_I_UP,
      FOL_O_LO, FOL_O_UP, FOL_U_LO, FOL_U_UP, FOL_UU_LO, FOL_UU_UP};

   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_out_last;

   int fail_count;
   int pending_count;
   int result_count;

   logic [7:0] text_bytes[$];
   int         burst_left = 0;
   int         bytes_sent = 0;
   int         strings_sent = 0;
   int         idle_cycles = 0;

   name_text_normalizer_top u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .empty       (empty),
      .pop         (pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_has_byte(rsp_has_byte),
      .rsp_out_last(rsp_out_last)
   );

   ntn_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .empty        (empty),
      .pop          (pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .result_count (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: switches between free popping, light stalls and long stalls.
   initial begin : receiver
      int stall_left;
      int mode;
      int mode_left;
      stall_left = 0;
      mode = 0;
      mode_left = 0;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 250);
         end
         mode_left--;
         if (reset) begin
            pop <= 1'b0;
         end else if (stall_left != 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            if (mode == 1 && $urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 2);
            else if (mode == 2 && $urandom_range(0, 4) == 0) stall_left = $urandom_range(3, 8);
         end
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("** name_text_normalizer_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one word; the sender idles for a random gap between bursts.
   task automatic send_word(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      push <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (full);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_word(text_bytes[i], i == text_bytes.size() - 1);
      strings_sent++;
      text_bytes.delete();
   endtask

   // Holds the sender off until every predicted word has come out or DRAIN_LIMIT runs out.
   task automatic wait_drained();
      int waited;
      waited = 0;
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Builds a random string, mostly names with accents and spacing mixed in.
   task automatic build_random_text();
      int target;
      int pick;
      if ($urandom_range(0, 11) == 0) begin
         // Whitespace only: the string must give the empty end marker.
         repeat ($urandom_range(1, 4)) text_bytes.push_back(SPACE_SET[$urandom_range(0, 5)]);
         return;
      end
      target = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      while (text_bytes.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            text_bytes.push_back(($urandom_range(0, 1) ? CHR_UP_A : CHR_LO_A) +
                                 8'($urandom_range(0, 25)));
         end else if (pick < 45) begin
            text_bytes.push_back(SPACE_SET[$urandom_range(0, 5)]);
         end else if (pick < 65) begin
            text_bytes.push_back(LEAD_BYTE);
            text_bytes.push_back(FOLLOWER_SET[$urandom_range(0, 11)]);
         end else if (pick < 70) begin
            text_bytes.push_back(LEAD_BYTE);
         end else if (pick < 85) begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            text_bytes.push_back(8'($urandom_range(CHR_BANG, CHR_TILDE)));
         end
      end
   endtask

   initial begin : stimulus
      int waited;
      int next_pause;
      reset = 1'b1;
      push = 1'b0;
      req_in_byte = '0;
      req_in_last = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Leading spaces, folds, a whitespace run, a lead before a lead, the
      // byte extremes and a trailing space on the last byte.
      text_bytes = '{WS_SPACE, WS_TAB, CHR_LO_M, LEAD_BYTE, FOL_A_LO, LEAD_BYTE, FOL_UU_UP,
                     WS_CR, WS_VT, CHR_UP_Q, LEAD_BYTE, LEAD_BYTE, FOL_UU_LO, BYTE_MIN,
                     BYTE_MAX, WS_SPACE};
      send_text();
      // A string of whitespace alone gives the empty end marker.
      text_bytes = '{WS_SPACE};
      send_text();
      // A lead at the end of a string passes unchanged.
      text_bytes = '{CHR_LO_R, LEAD_BYTE};
      send_text();
      // A lead with an ordinary follower passes, then the follower is shaped.
      text_bytes = '{LEAD_BYTE, CHR_UP_P};
      send_text();
      text_bytes = '{LEAD_BYTE};
      send_text();
      wait_drained();

      next_pause = bytes_sent + PAUSE_INTERVAL;
      while (bytes_sent < RANDOM_BYTES) begin
         build_random_text();
         send_text();
         if (bytes_sent >= next_pause) begin
            wait_drained();
            next_pause = bytes_sent + $urandom_range(PAUSE_INTERVAL / 2, PAUSE_INTERVAL * 2);
         end
      end

      // Let the last words drain, then give the block time to settle.
      push <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d bytes in %0d strings and checked %0d result words,",
               bytes_sent, strings_sent, result_count);
      $display("with accent folds, stray lead bytes and whitespace-only strings mixed in.");
      if (pending_count != 0) $error("%0d predicted result words never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** name_text_normalizer_top: PASSED **");
      end else begin
         $display("** name_text_normalizer_top: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
